[design/wia128_pkg.sv]
// ----------------------------------------------------------------------------
// wia128_pkg
// Types, opcodes and a helper function for the 128-bit integer ALU pipeline.
// ----------------------------------------------------------------------------
package wia128_pkg;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_SHL = 3'd2,
        CMD_SHR = 3'd3,
        CMD_MUL = 3'd4,
        CMD_DIV = 3'd5,
        CMD_CMP = 3'd6,
        CMD_RSV = 3'd7
    } cmd_t;

    localparam int unsigned DivBits        = 128;
    localparam int unsigned DivStepsPerStg = 8;
    localparam int unsigned NumDivStages   = DivBits / DivStepsPerStg;
    localparam int unsigned NumStages      = NumDivStages + 2;

    typedef struct packed {
        cmd_t          cmd;
        logic [127:0]  res;
        logic [31:0]   rem;
        logic [31:0]   divisor;
        logic          less_than;
        logic          equal_flag;
        logic          div_zero;
    } stage_t;

    typedef struct packed {
        logic [127:0] quo;
        logic [31:0]  rem;
    } div_state_t;

    // Eight restoring-division steps; quo shifts left, taking the dividend bits
    // out at the top and the quotient bits in at the bottom.
    function automatic div_state_t div_step8(input div_state_t s, input logic [31:0] d);
        div_state_t r;
        logic [32:0] t;
        r = s;
        for (int i = 0; i < DivStepsPerStg; i++)
        begin
            t = {r.rem, r.quo[127]};
            r.quo = {r.quo[126:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
                r.quo[0] = 1'b1;
            end
            r.rem = t[31:0];
        end
        return r;
    endfunction

endpackage

[design/wide_integer_alu_128.sv]
// ----------------------------------------------------------------------------
// wide_integer_alu_128
// Unsigned 128-bit ALU: add, subtract, shifts, compare, multiply and divide by 32 bits.
// ----------------------------------------------------------------------------
// The block takes one item per cycle unless a result waits at the output.
// The first stage does add, subtract, shifts, compares and four 32x32 partial
// products, the second sums the products, and sixteen stages of eight
// restoring-division steps each produce the 128 quotient bits. The whole pipe
// moves together and holds only while a result waits at the output.
module wide_integer_alu_128 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // a_high, a_low, b_high, b_low
    input  logic [2:0]   s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata   // res_high, res_low, remainder, less_than,
                                        // equal_flag, div_zero, zero fill
);

    wia128_pkg::stage_t st_reg [wia128_pkg::NumStages];
    wia128_pkg::stage_t st_next [wia128_pkg::NumStages];
    logic [wia128_pkg::NumStages-1:0] vld_reg;
    logic [wia128_pkg::NumStages-1:0] vld_next;
    logic [63:0] pp_reg [4];
    logic [63:0] pp_next [4];
    logic adv;

    logic [127:0] a_in;
    logic [127:0] b_in;
    logic [63:0]  sh_amt;
    logic [31:0]  m_in;

    assign a_in   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign b_in   = {s_axis_tdata[191:128], s_axis_tdata[255:192]};
    assign sh_amt = s_axis_tdata[255:192];
    assign m_in   = s_axis_tdata[223:192];

    assign adv           = !vld_reg[wia128_pkg::NumStages-1] || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        wia128_pkg::div_state_t ds;
        st_next[0].cmd        = wia128_pkg::cmd_t'(s_axis_tuser);
        st_next[0].res        = a_in;
        st_next[0].rem        = '0;
        st_next[0].divisor    = m_in;
        st_next[0].less_than  = a_in < b_in;
        st_next[0].equal_flag = a_in == b_in;
        st_next[0].div_zero   = 1'b0;
        unique case (wia128_pkg::cmd_t'(s_axis_tuser))
            wia128_pkg::CMD_ADD: st_next[0].res = a_in + b_in;
            wia128_pkg::CMD_SUB: st_next[0].res = a_in - b_in;
            wia128_pkg::CMD_SHL:
                st_next[0].res = (sh_amt[63:7] != '0) ? '0 : a_in << sh_amt[6:0];
            wia128_pkg::CMD_SHR:
                st_next[0].res = (sh_amt[63:7] != '0) ? '0 : a_in >> sh_amt[6:0];
            wia128_pkg::CMD_DIV:
            begin
                if (m_in == '0)
                begin
                    st_next[0].res      = '0;
                    st_next[0].div_zero = 1'b1;
                end
            end
            default: st_next[0].res = a_in;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            pp_next[i] = {32'd0, a_in[32*i +: 32]} * {32'd0, m_in};
        end

        st_next[1] = st_reg[0];
        if (st_reg[0].cmd == wia128_pkg::CMD_MUL)
        begin
            st_next[1].res = {64'd0, pp_reg[0]} + {32'd0, pp_reg[1], 32'd0}
                           + {pp_reg[2], 64'd0} + {pp_reg[3][31:0], 96'd0};
        end

        for (int k = 2; k < wia128_pkg::NumStages; k++)
        begin
            st_next[k] = st_reg[k-1];
            ds.quo = st_reg[k-1].res;
            ds.rem = st_reg[k-1].rem;
            if (st_reg[k-1].cmd == wia128_pkg::CMD_DIV && !st_reg[k-1].div_zero)
            begin
                ds = wia128_pkg::div_step8(ds, st_reg[k-1].divisor);
                st_next[k].res = ds.quo;
                st_next[k].rem = ds.rem;
            end
        end

        vld_next = {vld_reg[wia128_pkg::NumStages-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < wia128_pkg::NumStages; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            for (int i = 0; i < 4; i++)
            begin
                pp_reg[i] <= pp_next[i];
            end
        end
    end

    assign m_axis_tvalid = vld_reg[wia128_pkg::NumStages-1];
    assign m_axis_tdata  = {5'd0,
                            st_reg[wia128_pkg::NumStages-1].div_zero,
                            st_reg[wia128_pkg::NumStages-1].equal_flag,
                            st_reg[wia128_pkg::NumStages-1].less_than,
                            st_reg[wia128_pkg::NumStages-1].rem,
                            st_reg[wia128_pkg::NumStages-1].res[63:0],
                            st_reg[wia128_pkg::NumStages-1].res[127:64]};

    a_divzero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[162] |-> m_axis_tdata[159:0] == '0)
        else $error("Division by zero result is not zero.");

    a_eq_not_lt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[161] |-> !m_axis_tdata[160])
        else $error("Equal and less-than flags both set.");

    a_rem_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && st_reg[wia128_pkg::NumStages-1].cmd != wia128_pkg::CMD_DIV
        |-> m_axis_tdata[159:128] == '0)
        else $error("Nonzero remainder outside division.");

endmodule
